### hw/rtl/gdbo_pkg.sv
`timescale 1ns / 1ps
package gdbo_pkg;
	localparam int VW = 7;
	localparam int NMAX = 64;
	localparam int IW = 6;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_DFS = 2'd1,
		OP_BFS = 2'd2,
		OP_CLR = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ADD2,
		ST_START,
		ST_DFS_RD,
		ST_DFS_SCAN,
		ST_BFS_RD,
		ST_BFS_SCAN,
		ST_ROW,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clr_row;
		logic add_a;
		logic add_b;
		logic start;
		logic rd_top;
		logic rd_head;
		logic rd_row;
		logic dfs_step;
		logic bfs_step;
		logic bfs_emit;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic found;
		logic stack_empty;
		logic queue_done;
		logic out_busy;
	} sts_t;
endpackage

### hw/rtl/gdbo_ctrl.sv
`timescale 1ns / 1ps
module gdbo_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  gdbo_pkg::op_t  op,
	input  logic           a_ok,
	input  logic           b_ok,
	input  gdbo_pkg::sts_t sts,
	output gdbo_pkg::cmd_t cmd,
	output logic           idle
);
	import gdbo_pkg::*;

	state_t state_q, state_d;
	logic   dfs_q, dfs_d;

	// After reset the adjacency rows are wiped by one clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			dfs_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			dfs_q   <= dfs_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dfs_d   = dfs_q;
		cmd     = '0;
		idle    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					case (op)
						OP_ADD: if (a_ok && b_ok) begin
							cmd.add_a = 1'b1;
							state_d   = ST_ADD2;
						end
						OP_CLR: state_d = ST_CLEAR;
						default: if (a_ok) begin
							// Depth-first holds the start vertex right away.
							cmd.start = 1'b1;
							cmd.emit  = (op == OP_DFS);
							dfs_d     = (op == OP_DFS);
							state_d   = ST_START;
						end
					endcase
				end
			end
			ST_ADD2: begin
				cmd.add_b = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.clr_row = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_START: begin
				state_d = dfs_q ? ST_DFS_RD : ST_BFS_RD;
			end
			ST_DFS_RD: begin
				if (sts.stack_empty) state_d = ST_EMIT;
				else begin
					cmd.rd_top = 1'b1;
					state_d    = ST_ROW;
				end
			end
			ST_ROW: begin
				cmd.rd_row = 1'b1;
				state_d    = dfs_q ? ST_DFS_SCAN : ST_BFS_SCAN;
			end
			ST_DFS_SCAN: begin
				if (!sts.found || !sts.out_busy) begin
					cmd.dfs_step = 1'b1;
					if (sts.found) cmd.emit = 1'b1;
					state_d = ST_DFS_RD;
				end
			end
			ST_BFS_RD: begin
				if (sts.queue_done) state_d = ST_EMIT;
				else begin
					cmd.rd_head = 1'b1;
					state_d     = ST_ROW;
				end
			end
			ST_BFS_SCAN: begin
				// Neighbors are queued one per cycle; the vertex itself goes out after that.
				if (sts.found) begin
					cmd.bfs_step = 1'b1;
				end else if (!sts.out_busy) begin
					cmd.bfs_emit = 1'b1;
					cmd.emit     = 1'b1;
					state_d      = ST_BFS_RD;
				end
			end
			ST_EMIT: begin
				// Flush the held result with the last flag set.
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### hw/rtl/gdbo_dp.sv
`timescale 1ns / 1ps
module gdbo_dp #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [gdbo_pkg::VW-1:0]  va,
	input  logic [gdbo_pkg::VW-1:0]  vb,
	input  gdbo_pkg::cmd_t           cmd,
	output gdbo_pkg::sts_t           sts,
	output logic                     a_ok,
	output logic                     b_ok,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [gdbo_pkg::VW-1:0]  out_vertex,
	output logic                     out_last
);
	import gdbo_pkg::*;

	localparam int N = MAX_VERTICES;

	logic [N-1:0] adj_mem [N];
	logic [N-1:0] row_q;
	logic [N-1:0] visited_q;
	logic [IW-1:0] stk_v [NMAX];
	logic [IW:0]   stk_n [NMAX];
	logic [IW-1:0] que [NMAX];
	logic [IW:0]   sp_q, head_q, tail_q;
	logic [IW-1:0] clr_q;
	logic [IW-1:0] cur_v_q;
	logic [IW:0]   cur_n_q;
	logic [IW-1:0] ua, ub;
	// Held result: emitted one step late so the final one can carry last.
	logic          hold_v_q;
	logic [IW-1:0] hold_q;
	logic [IW-1:0] emit_v;
	logic          step_emit;

	assign a_ok = (va >= VW'(1)) && (va <= VW'(N));
	assign b_ok = (vb >= VW'(1)) && (vb <= VW'(N));
	assign ua   = IW'(va - VW'(1));
	assign ub   = IW'(vb - VW'(1));

	// Candidates: neighbors not visited at or above the resume index.
	logic [N-1:0] cand;
	logic         found;
	logic [IW-1:0] first;
	always_comb begin
		cand  = row_q & ~visited_q;
		found = 1'b0;
		first = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (cand[i] && (i >= int'(cur_n_q))) begin
				found = 1'b1;
				first = IW'(i);
			end
		end
	end

	always_comb begin
		emit_v = hold_q;
		if (cmd.start) emit_v = ua;
		else if (cmd.dfs_step) emit_v = first;
		else if (cmd.bfs_emit) emit_v = cur_v_q;
	end

	assign step_emit = cmd.start || cmd.dfs_step || cmd.bfs_emit;

	logic out_busy;
	assign out_busy = out_valid && !out_ready;

	assign sts.clr_done    = (clr_q == IW'(N - 1));
	assign sts.found       = found;
	assign sts.stack_empty = (sp_q == '0);
	assign sts.queue_done  = (head_q == tail_q);
	assign sts.out_busy    = out_busy;

	always_ff @(posedge clk) begin
		if (cmd.add_a) adj_mem[ua][ub] <= 1'b1;
		else if (cmd.add_b) adj_mem[cur_v_q][cur_n_q[IW-1:0]] <= 1'b1;
		else if (cmd.clr_row) adj_mem[clr_q] <= '0;
		if (cmd.rd_row) row_q <= adj_mem[cur_v_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			stk_v[0] <= ua;
			stk_n[0] <= '0;
			que[0]   <= ua;
		end
		if (cmd.dfs_step && found) begin
			stk_n[sp_q[IW-1:0] - IW'(1)] <= {1'b0, first} + (IW+1)'(1);
			if (sp_q != (IW+1)'(NMAX)) begin
				stk_v[sp_q[IW-1:0]] <= first;
				stk_n[sp_q[IW-1:0]] <= '0;
			end
		end
		if (cmd.bfs_step) que[tail_q[IW-1:0]] <= first;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			sp_q      <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			clr_q     <= '0;
			cur_v_q   <= '0;
			cur_n_q   <= '0;
			hold_v_q  <= 1'b0;
			hold_q    <= '0;
			out_valid <= 1'b0;
			out_vertex <= '0;
			out_last  <= 1'b0;
		end else begin
			if (cmd.clr_row) clr_q <= clr_q + IW'(1);
			else clr_q <= '0;
			if (cmd.add_a) begin
				cur_v_q <= ub;
				cur_n_q <= {1'b0, ua};
			end
			if (cmd.start) begin
				visited_q <= N'(1) << ua;
				sp_q      <= (IW+1)'(1);
				head_q    <= '0;
				tail_q    <= (IW+1)'(1);
			end
			if (cmd.rd_top) begin
				cur_v_q <= stk_v[sp_q[IW-1:0] - IW'(1)];
				cur_n_q <= stk_n[sp_q[IW-1:0] - IW'(1)];
			end
			if (cmd.rd_head) begin
				cur_v_q <= que[head_q[IW-1:0]];
				cur_n_q <= '0;
				head_q  <= head_q + (IW+1)'(1);
			end
			if (cmd.dfs_step) begin
				if (found) begin
					visited_q[first] <= 1'b1;
					if (sp_q != (IW+1)'(NMAX)) sp_q <= sp_q + (IW+1)'(1);
				end else begin
					sp_q <= sp_q - (IW+1)'(1);
				end
			end
			if (cmd.bfs_step) begin
				visited_q[first] <= 1'b1;
				tail_q           <= tail_q + (IW+1)'(1);
			end
			if (cmd.emit && (!step_emit || hold_v_q)) begin
				out_valid  <= hold_v_q;
				out_vertex <= VW'(hold_q) + VW'(1);
				out_last   <= !step_emit;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.emit) begin
				hold_v_q <= step_emit;
				if (step_emit) hold_q <= emit_v;
			end
		end
	end
endmodule

### hw/rtl/graph_dfs_bfs_order.sv
`timescale 1ns / 1ps
// Reset clears all control and then wipes the adjacency rows, input held off.
// An edge request sets both directions of the edge in turn (none if an end is out of range); a clear wipes all rows.
// Depth-first: start, then read top, read row and scan for each stack push or pop, then flush the last.
// Breadth-first: start, then read head, read row and scan for each dequeued vertex, queuing its neighbors, then flush.
// Each result is held until the next is found, then enters the output register; a busy output
// stalls the walk, and no request is taken until the run has ended.
module graph_dfs_bfs_order #(
	parameter int MAX_VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // opcode[1:0], vertex_a[8:2], vertex_b[15:9]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // vertex[6:0], zero[7]
	output logic        m_tlast
);
	import gdbo_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic a_ok, b_ok, idle;
	logic [VW-1:0] vtx;

	assign s_tready = idle;
	assign m_tdata  = {1'b0, vtx};

	gdbo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.op(op_t'(s_tdata[1:0])), .a_ok(a_ok), .b_ok(b_ok),
		.sts(sts), .cmd(cmd), .idle(idle)
	);

	gdbo_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk(clk), .arst_n(arst_n), .va(s_tdata[8:2]), .vb(s_tdata[15:9]),
		.cmd(cmd), .sts(sts), .a_ok(a_ok), .b_ok(b_ok),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_vertex(vtx), .out_last(m_tlast)
	);
endmodule

### hw/rtl/gdbo_check.sv
`timescale 1ns / 1ps
module gdbo_check (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       s_tready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output changed");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:0] != 7'd0 && m_tdata[7] == 1'b0) else $error("bad vertex");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !s_tready |=> !s_tready || m_tvalid) else $error("early ready");
endmodule

bind graph_dfs_bfs_order gdbo_check u_check (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .s_tready(s_tready)
);

### tb/graph_dfs_bfs_order_checker.sv
`timescale 1ns / 1ps
module graph_dfs_bfs_order_checker
	import gdbo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	output int          errors,
	output int          pending,
	output int          visits_checked
);
	typedef struct packed {
		logic [VW-1:0] vertex;
		logic          last;
	} visit_t;

	visit_t      visit_q[$];
	logic [63:0] adj_rows[NMAX];
	logic [63:0] seen;
	int          order[$];

	function automatic int next_neighbor(int v, int from);
		for (int w = from; w < NMAX; w++)
			if (adj_rows[v][w] && !seen[w])
				return w;
		return -1;
	endfunction

	function automatic void walk_depth(int s);
		int stk_v[NMAX];
		int stk_n[NMAX];
		int sp;
		int w;
		seen[s] = 1'b1;
		order.insert(order.size(), s);
		stk_v[0] = s;
		stk_n[0] = 0;
		sp = 1;
		while (sp > 0) begin
			w = next_neighbor(stk_v[sp-1], stk_n[sp-1]);
			if (w < 0) begin
				sp--;
			end else begin
				stk_n[sp-1] = w + 1;
				seen[w] = 1'b1;
				order.insert(order.size(), w);
				if (sp < NMAX) begin
					stk_v[sp] = w;
					stk_n[sp] = 0;
					sp++;
				end
			end
		end
	endfunction

	function automatic void walk_breadth(int s);
		int fifo[$];
		int v;
		seen[s] = 1'b1;
		fifo.insert(fifo.size(), s);
		while (fifo.size() > 0) begin
			v = fifo.pop_front();
			order.insert(order.size(), v);
			for (int w = 0; w < NMAX; w++)
				if (adj_rows[v][w] && !seen[w]) begin
					seen[w] = 1'b1;
					fifo.insert(fifo.size(), w);
				end
		end
	endfunction

	function automatic void predict_request(logic [15:0] d);
		op_t op;
		int  a;
		int  b;
		bit  a_ok;
		bit  b_ok;
		op = op_t'(d[1:0]);
		a = d[8:2];
		b = d[15:9];
		a_ok = a >= 1 && a <= NMAX;
		b_ok = b >= 1 && b <= NMAX;
		case (op)
			OP_CLR: begin
				for (int i = 0; i < NMAX; i++)
					adj_rows[i] = '0;
			end
			OP_ADD: begin
				if (a_ok && b_ok) begin
					adj_rows[a-1][b-1] = 1'b1;
					adj_rows[b-1][a-1] = 1'b1;
				end
			end
			default: begin
				// A start vertex out of range leaves the visited marks alone.
				if (a_ok) begin
					seen = '0;
					order.delete();
					if (op == OP_DFS)
						walk_depth(a - 1);
					else
						walk_breadth(a - 1);
					foreach (order[i])
						visit_q.insert(visit_q.size(),
							{VW'(order[i] + 1), i == order.size() - 1});
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		visit_t exp;
		if (!arst_n) begin
			for (int i = 0; i < NMAX; i++)
				adj_rows[i] = '0;
			seen = '0;
			visit_q.delete();
			errors = 0;
			visits_checked = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (visit_q.size() == 0) begin
					$error("unexpected result: vertex %0d last %0b", m_tdata[6:0], m_tlast);
					errors++;
				end else begin
					exp = visit_q.pop_front();
					visits_checked++;
					if (m_tdata[6:0] !== exp.vertex) begin
						$error("vertex: expected %0d, got %0d", exp.vertex, m_tdata[6:0]);
						errors++;
					end
					if (m_tlast !== exp.last) begin
						$error("last: expected %0b, got %0b", exp.last, m_tlast);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_request(s_tdata);
		end
		pending = visit_q.size();
	end
endmodule

### tb/graph_dfs_bfs_order_tb.sv
`timescale 1ns / 1ps
module graph_dfs_bfs_order_tb;
	import gdbo_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int ITEM_TARGET = 370;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	int          errors;
	int          pending;
	int          visits_checked;
	int          cycles;
	int          sent;
	int          runs_sent;
	bit          long_hold;

	graph_dfs_bfs_order #(.MAX_VERTICES(NMAX)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	graph_dfs_bfs_order_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.errors(errors), .pending(pending), .visits_checked(visits_checked)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: mostly short stalls, a few long ones, calm stretches, and one long hold.
	initial begin
		int gap_left;
		int calm_left;
		int r;
		gap_left = 0;
		calm_left = 0;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready = 1'b0;
				repeat (400) @(negedge clk);
				long_hold = 1'b0;
			end else if (calm_left > 0) begin
				m_tready = 1'b1;
				calm_left--;
			end else if (gap_left > 0) begin
				m_tready = 1'b0;
				gap_left--;
			end else begin
				m_tready = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 20)
					gap_left = $urandom_range(1, 3);
				else if (r < 23)
					gap_left = $urandom_range(10, 50);
				else if (r < 25)
					calm_left = $urandom_range(50, 200);
			end
		end
	end

	task automatic send_request(op_t op, int a, int b);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		gap = r < 60 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tdata = {b[6:0], a[6:0], op};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sent++;
		if (op == OP_DFS || op == OP_BFS)
			runs_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	function automatic int any_vertex();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 0;
		if (r < 8)
			return $urandom_range(65, 127);
		return $urandom_range(1, 64);
	endfunction

	initial begin
		int span;
		int base;
		int n_edges;
		int n_runs;
		int phase;
		long_hold = 1'b0;
		sent = 0;
		runs_sent = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: isolated starts, self-loops, duplicates, out-of-range ends.
		send_request(OP_CLR, 1, 1);
		send_request(OP_DFS, 1, 0);
		send_request(OP_BFS, 64, 127);
		send_request(OP_ADD, 1, 1);
		send_request(OP_ADD, 0, 5);
		send_request(OP_ADD, 65, 3);
		send_request(OP_ADD, 127, 127);
		send_request(OP_DFS, 0, 0);
		send_request(OP_BFS, 127, 0);
		send_request(OP_ADD, 1, 2);
		send_request(OP_ADD, 2, 1);
		send_request(OP_ADD, 1, 3);
		send_request(OP_ADD, 2, 4);
		send_request(OP_ADD, 3, 4);
		send_request(OP_ADD, 64, 1);
		send_request(OP_ADD, 42, 85);
		send_request(OP_DFS, 1, 0);
		send_request(OP_BFS, 1, 0);
		send_request(OP_DFS, 64, 0);
		send_request(OP_BFS, 4, 0);
		send_request(OP_CLR, 0, 0);
		send_request(OP_DFS, 1, 0);
		wait_drained();

		// A path through all vertices gives the longest runs; hold the receiver meanwhile.
		for (int v = 1; v < NMAX; v++)
			send_request(OP_ADD, v, v + 1);
		long_hold = 1'b1;
		send_request(OP_DFS, 1, 0);
		send_request(OP_BFS, 32, 0);
		send_request(OP_DFS, 64, 0);
		send_request(OP_BFS, 1, 0);
		wait_drained();

		phase = 0;
		while (sent < ITEM_TARGET) begin
			send_request(OP_CLR, $urandom_range(0, 127), $urandom_range(0, 127));
			span = ($urandom_range(0, 9) == 0) ? NMAX : $urandom_range(3, 16);
			base = $urandom_range(1, NMAX - span + 1);
			n_edges = $urandom_range(2, span + 4);
			for (int i = 0; i < n_edges; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_request(OP_ADD, any_vertex(), any_vertex());
				else
					send_request(OP_ADD, base + $urandom_range(0, span - 1),
						base + $urandom_range(0, span - 1));
			end
			n_runs = $urandom_range(2, 4);
			for (int i = 0; i < n_runs; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_request($urandom_range(0, 1) ? OP_DFS : OP_BFS, any_vertex(),
						$urandom_range(0, 127));
				else
					send_request($urandom_range(0, 1) ? OP_DFS : OP_BFS,
						base + $urandom_range(0, span - 1), $urandom_range(0, 127));
			end
			phase++;
			if (phase % 7 == 0)
				wait_drained();
		end

		wait_drained();
		repeat (300) @(posedge clk);
		$display("Sent %0d requests including %0d depth/breadth runs on random graphs,",
			sent, runs_sent);
		$display("with a full-length path, out-of-range vertices and %0d visits checked.",
			visits_checked);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
